// ----- design/lscp_pkg.sv -----
// package for the slot cache directory: constants, operation codes, beat types
// no dependencies; imported by lscp_front, lscp_back and the top level

package lscp_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int ID_WIDTH_DEF = 16;
    localparam int LANES        = 4;
    localparam int LANE_W       = 2;
    localparam int STAMP_W      = 32;
    localparam int PATCH_W      = 16;
    localparam int SLOT_OUT_W   = 7;

    // request modes as they arrive on the port
    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_STALE  = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_FLUSH  = 2'd3
    } mode_t;

    // operations after classification in the front end
    typedef enum logic [2:0] {
        OP_FREE  = 3'd0,
        OP_FILL  = 3'd1,
        OP_MARK  = 3'd2,
        OP_TICK  = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BS_IDLE   = 2'd0,
        BS_SCAN   = 2'd1,
        BS_COMMIT = 2'd2
    } back_state_t;

    typedef struct packed {
        mode_t               mode;
        logic [PATCH_W-1:0]  patch_id;
        logic                source_present;
        logic                overlay_dirty;
    } req_t;

    typedef struct packed {
        logic                   granted;
        logic                   hit;
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic                   refill_needed;
        logic                   evicted;
        logic [PATCH_W-1:0]     evicted_id;
    } rsp_t;

    // classified item held in the queue between front and back
    typedef struct packed {
        op_t                 op;
        logic [PATCH_W-1:0]  id;
        logic                dirty;
    } item_t;

endpackage

// ----- design/lscp_ram.sv -----
// generic single write port memory with one registered read port
// no dependencies

module lscp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/lscp_front.sv -----
// front end: accepts request beats, classifies them, two-entry queue to the back end
// depends on lscp_pkg

module lscp_front
    import lscp_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    input  req_t   req,
    output logic   item_valid,
    input  logic   item_pop,
    output item_t  item
);

    localparam int KEEP_W = (ID_WIDTH < PATCH_W) ? ID_WIDTH : PATCH_W;

    item_t       cls;
    item_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;

    // classify the beat and mask the id to the tag width
    always_comb
    begin
        cls                   = '0;
        cls.id[KEEP_W-1:0]    = req.patch_id[KEEP_W-1:0];
        cls.dirty             = req.overlay_dirty;
        unique case (req.mode)
            MODE_LOOKUP: cls.op = req.source_present ? OP_FILL : OP_FREE;
            MODE_STALE:  cls.op = OP_MARK;
            MODE_TICK:   cls.op = OP_TICK;
            MODE_FLUSH:  cls.op = OP_FLUSH;
        endcase
    end

    // queue handshake
    assign req_stall  = (count_reg == 2'd2);
    assign push       = req_valid && !req_stall;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !item_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- design/lscp_back.sv -----
// back end: directory state, row scan over tag and stamp memories, commit and result register
// depends on lscp_pkg and lscp_ram

module lscp_back
    import lscp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_pop,
    input  item_t  item,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output rsp_t   rsp
);

    localparam int ROWS_RAW = (CAPACITY + LANES - 1) / LANES;
    localparam int ROWS     = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int IDX_W    = ROW_W + LANE_W;
    localparam int SLOTS    = ROWS * LANES;
    localparam int CNT_W    = $clog2(ROWS + 2);
    localparam int KEEP_W   = (ID_WIDTH < PATCH_W) ? ID_WIDTH : PATCH_W;
    localparam int IDXO_W   = (IDX_W < SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam logic [IDX_W:0]   CAP_L    = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] ROWS_L   = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ROWS + 1);

    back_state_t           state_reg;
    back_state_t           state_next;
    item_t                 cur_reg;
    logic [STAMP_W-1:0]    now_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [SLOTS-1:0]      stale_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  scan_on;
    logic                  commit_fire;
    logic [ID_WIDTH-1:0]   tag_key;

    // memory read side
    logic                  rd_valid_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic [ID_WIDTH-1:0]   tag_rd   [LANES];
    logic [STAMP_W-1:0]    stamp_rd [LANES];

    // per-row lane results
    logic [LANES-1:0]      lane_valid;
    logic [LANES-1:0]      lane_match;
    logic [LANES-1:0]      lane_free;
    logic [LANE_W-1:0]     match_lane;
    logic [LANE_W-1:0]     free_lane;
    logic                  pa_lo, pa_ok, pb_lo, pb_ok, m_lo, m_ok;
    logic [LANE_W-1:0]     pa_lane, pb_lane, m_lane;
    logic [STAMP_W-1:0]    pa_stamp, pb_stamp, m_stamp;
    logic [ID_WIDTH-1:0]   pa_tag, pb_tag, m_tag;

    // row stage registers
    logic                  s1_valid_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic                  s1_match_reg;
    logic [LANE_W-1:0]     s1_match_lane_reg;
    logic                  s1_free_reg;
    logic [LANE_W-1:0]     s1_free_lane_reg;
    logic                  s1_any_reg;
    logic [LANE_W-1:0]     s1_min_lane_reg;
    logic [STAMP_W-1:0]    s1_min_stamp_reg;
    logic [ID_WIDTH-1:0]   s1_min_tag_reg;

    // running scan results
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic                  free_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  best_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [STAMP_W-1:0]    best_stamp_reg;
    logic [ID_WIDTH-1:0]   best_tag_reg;

    // commit controls
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic                  valid_wr, valid_val, stale_wr, stale_val;
    logic                  flush_all, tick;
    rsp_t                  rsp_next;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;

    // tag key at the stored width
    always_comb
    begin
        tag_key               = '0;
        tag_key[KEEP_W-1:0]   = cur_reg.id[KEEP_W-1:0];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == OP_TICK || item.op == OP_FLUSH)
                    begin
                        state_next = BS_COMMIT;
                    end
                    else
                    begin
                        state_next = BS_SCAN;
                    end
                end
            end
            BS_SCAN:
            begin
                if (cnt_reg == SCAN_END)
                begin
                    state_next = BS_COMMIT;
                end
            end
            BS_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_pop    = 1'b0;
        scan_on     = 1'b0;
        commit_fire = 1'b0;
        unique case (state_reg)
            BS_IDLE:   item_pop    = item_valid;
            BS_SCAN:   scan_on     = 1'b1;
            BS_COMMIT: commit_fire = !rsp_valid_reg || !rsp_stall;
            default:   item_pop    = 1'b0;
        endcase
    end

    // tag and stamp memories, one of each per lane, all lanes read the same row
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic lane_we;

        assign lane_we = wr_en && (wr_idx[LANE_W-1:0] == LANE_W'(l));

        lscp_ram #(
            .WIDTH (ID_WIDTH),
            .DEPTH (ROWS)
        ) u_tag_ram (
            .clk   (clk),
            .we    (lane_we),
            .waddr (wr_idx[IDX_W-1:LANE_W]),
            .wdata (tag_key),
            .raddr (cnt_reg[ROW_W-1:0]),
            .rdata (tag_rd[l])
        );

        lscp_ram #(
            .WIDTH (STAMP_W),
            .DEPTH (ROWS)
        ) u_stamp_ram (
            .clk   (clk),
            .we    (lane_we),
            .waddr (wr_idx[IDX_W-1:LANE_W]),
            .wdata (now_reg),
            .raddr (cnt_reg[ROW_W-1:0]),
            .rdata (stamp_rd[l])
        );
    end

    // lane classification for the row coming out of the memories
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_valid[l] = valid_reg[{rd_row_reg, LANE_W'(l)}];
            lane_match[l] = lane_valid[l] && (tag_rd[l] == tag_key);
            lane_free[l]  = !lane_valid[l] && ({1'b0, rd_row_reg, LANE_W'(l)} < CAP_L);
        end
    end

    // lowest matching lane and lowest free lane
    always_comb
    begin
        match_lane = '0;
        free_lane  = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_match[l])
            begin
                match_lane = LANE_W'(l);
            end
            if (lane_free[l])
            begin
                free_lane = LANE_W'(l);
            end
        end
    end

    // oldest valid lane in the row, lower lane wins ties
    always_comb
    begin
        pa_lo    = !lane_valid[1] || (lane_valid[0] && (stamp_rd[0] <= stamp_rd[1]));
        pa_ok    = lane_valid[0] || lane_valid[1];
        pa_lane  = pa_lo ? LANE_W'(0) : LANE_W'(1);
        pa_stamp = pa_lo ? stamp_rd[0] : stamp_rd[1];
        pa_tag   = pa_lo ? tag_rd[0] : tag_rd[1];
        pb_lo    = !lane_valid[3] || (lane_valid[2] && (stamp_rd[2] <= stamp_rd[3]));
        pb_ok    = lane_valid[2] || lane_valid[3];
        pb_lane  = pb_lo ? LANE_W'(2) : LANE_W'(3);
        pb_stamp = pb_lo ? stamp_rd[2] : stamp_rd[3];
        pb_tag   = pb_lo ? tag_rd[2] : tag_rd[3];
        m_lo     = !pb_ok || (pa_ok && (pa_stamp <= pb_stamp));
        m_ok     = pa_ok || pb_ok;
        m_lane   = m_lo ? pa_lane : pb_lane;
        m_stamp  = m_lo ? pa_stamp : pb_stamp;
        m_tag    = m_lo ? pa_tag : pb_tag;
    end

    // row stage payload
    always_ff @(posedge clk)
    begin
        s1_row_reg        <= rd_row_reg;
        s1_match_reg      <= |lane_match;
        s1_match_lane_reg <= match_lane;
        s1_free_reg       <= |lane_free;
        s1_free_lane_reg  <= free_lane;
        s1_any_reg        <= m_ok;
        s1_min_lane_reg   <= m_lane;
        s1_min_stamp_reg  <= m_stamp;
        s1_min_tag_reg    <= m_tag;
        rd_row_reg        <= cnt_reg[ROW_W-1:0];
    end

    // running results over rows, in increasing slot order
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
        end
        if (s1_valid_reg && s1_match_reg && !found_reg)
        begin
            found_idx_reg <= {s1_row_reg, s1_match_lane_reg};
        end
        if (s1_valid_reg && s1_free_reg && !free_reg)
        begin
            free_idx_reg <= {s1_row_reg, s1_free_lane_reg};
        end
        if (s1_valid_reg && s1_any_reg && (!best_reg || (s1_min_stamp_reg < best_stamp_reg)))
        begin
            best_idx_reg   <= {s1_row_reg, s1_min_lane_reg};
            best_stamp_reg <= s1_min_stamp_reg;
            best_tag_reg   <= s1_min_tag_reg;
        end
    end

    // commit decisions and result beat
    always_comb
    begin
        rsp_next  = '0;
        wr_en     = 1'b0;
        wr_idx    = found_idx_reg;
        valid_wr  = 1'b0;
        valid_val = 1'b0;
        stale_wr  = 1'b0;
        stale_val = 1'b0;
        flush_all = 1'b0;
        tick      = 1'b0;
        unique case (cur_reg.op)
            OP_FREE:
            begin
                if (found_reg)
                begin
                    valid_wr            = 1'b1;
                    stale_wr            = 1'b1;
                    rsp_next.evicted    = 1'b1;
                    rsp_next.evicted_id = cur_reg.id;
                end
            end
            OP_FILL:
            begin
                rsp_next.granted = 1'b1;
                wr_en            = 1'b1;
                stale_wr         = 1'b1;
                if (found_reg)
                begin
                    rsp_next.hit           = 1'b1;
                    rsp_next.refill_needed = stale_reg[found_idx_reg] || cur_reg.dirty;
                end
                else
                begin
                    wr_idx                 = free_reg ? free_idx_reg : best_idx_reg;
                    valid_wr               = 1'b1;
                    valid_val              = 1'b1;
                    rsp_next.refill_needed = 1'b1;
                    if (!free_reg)
                    begin
                        rsp_next.evicted                    = 1'b1;
                        rsp_next.evicted_id[KEEP_W-1:0]     = best_tag_reg[KEEP_W-1:0];
                    end
                end
                rsp_next.slot_index[IDXO_W-1:0] = wr_idx[IDXO_W-1:0];
            end
            OP_MARK:
            begin
                stale_wr  = found_reg;
                stale_val = 1'b1;
            end
            OP_TICK:
            begin
                tick = 1'b1;
            end
            OP_FLUSH:
            begin
                flush_all = 1'b1;
                tick      = 1'b1;
            end
            default:
            begin
                tick = 1'b0;
            end
        endcase
        wr_en = wr_en && commit_fire;
    end

    // control state, slot flags, stamp and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            best_reg      <= 1'b0;
            valid_reg     <= '0;
            stale_reg     <= '0;
            now_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= scan_on && (cnt_reg < ROWS_L);
            s1_valid_reg <= rd_valid_reg;

            // scan row counter
            if (item_pop)
            begin
                cnt_reg <= '0;
            end
            else if (scan_on)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // running flags
            if (item_pop)
            begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                best_reg  <= 1'b0;
            end
            else if (s1_valid_reg)
            begin
                found_reg <= found_reg || s1_match_reg;
                free_reg  <= free_reg || s1_free_reg;
                best_reg  <= best_reg || s1_any_reg;
            end

            // slot flags and stamp on commit
            if (commit_fire)
            begin
                if (flush_all)
                begin
                    valid_reg <= '0;
                    stale_reg <= '0;
                end
                else
                begin
                    if (valid_wr)
                    begin
                        valid_reg[wr_idx] <= valid_val;
                    end
                    if (stale_wr)
                    begin
                        stale_reg[wr_idx] <= stale_val;
                    end
                end
                if (tick)
                begin
                    now_reg <= now_reg + STAMP_W'(1);
                end
            end

            // result beat handshake
            if (commit_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- design/lru_slot_cache_policy.sv -----
// top level of the slot cache directory with least-recently-used replacement
// depends on lscp_pkg, lscp_front, lscp_back (and lscp_ram below it)
//
// usage:
//   request beats enter on req_valid / req_stall / req, one result beat per
//   request leaves on rsp_valid / rsp_stall / rsp. a beat moves at a rising
//   edge with valid high and stall low.
//   the front end classifies each beat and holds up to two in a queue, so it
//   keeps accepting while the back end works or a result waits.
//   lookup and mark-stale beats scan the directory four slots a cycle through
//   the per-lane tag and stamp memories, one row of four slots at a time,
//   over ROWS rows, where ROWS = ceil(CAPACITY / 4) with a floor of 2.
//   tick and flush beats skip the scan and go straight to commit.
//   reset clears the slot valid and stale flags and the time stamp at once;
//   tag and stamp memories are not cleared; their contents are used only for valid slots.
//   a stalled result holds in the output register; the back end then waits
//   at commit and the queue fills, after which req_stall rises.

module lru_slot_cache_policy
    import lscp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    logic   item_valid;
    logic   item_pop;
    item_t  item;

    // accept and classify
    lscp_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    // directory engine
    lscp_back #(
        .CAPACITY (CAPACITY),
        .ID_WIDTH (ID_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// ----- bench/tb_lru_slot_cache_policy.sv -----
// self-checking bench for lru_slot_cache_policy: directed table, then random traffic
// depends on lscp_pkg and the block's rtl; predicts every result beat locally
`timescale 1ns / 1ps

module tb_lru_slot_cache_policy;
    import lscp_pkg::*;

    localparam int SLOTS       = 128;
    localparam int RANDOM_N    = 650;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    lru_slot_cache_policy u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // local copy of the directory
    bit          dir_valid [SLOTS];
    bit [15:0]   dir_tag   [SLOTS];
    bit [31:0]   dir_stamp [SLOTS];
    bit          dir_stale [SLOTS];
    bit [31:0]   dir_now;

    // stimulus list and typed-in answers for the directed rows
    req_t        stim_q[$];
    bit          typed_q[$];
    rsp_t        typed_rsp_q[$];
    rsp_t        pending_rsp_q[$];
    bit [15:0]   recent_ids[$];

    int          beats_taken = 0;
    int          cur_idx = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    bit [31:0]   stall_bits = '0;
    int          fails = 0;
    int          cycles = 0;
    int          n_results = 0;
    int          n_hit = 0;
    int          n_miss = 0;
    int          n_evict = 0;
    int          n_free = 0;
    int          n_mark = 0;
    int          n_tick = 0;
    int          n_flush = 0;

    // one directory operation: updates the local state, returns the result beat
    function automatic rsp_t directory_step(input req_t r);
        rsp_t o;
        int   s;
        int   v;
        o = '0;
        s = -1;
        v = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (s < 0 && dir_valid[i] && dir_tag[i] == r.patch_id)
                s = i;
        end
        unique case (r.mode)
            MODE_LOOKUP:
            begin
                if (!r.source_present)
                begin
                    if (s >= 0)
                    begin
                        dir_valid[s] = 1'b0;
                        dir_stale[s] = 1'b0;
                        o.evicted    = 1'b1;
                        o.evicted_id = r.patch_id;
                        n_free++;
                    end
                end
                else if (s >= 0)
                begin
                    o.granted       = 1'b1;
                    o.hit           = 1'b1;
                    o.slot_index    = s[6:0];
                    o.refill_needed = dir_stale[s] | r.overlay_dirty;
                    dir_stale[s]    = 1'b0;
                    dir_stamp[s]    = dir_now;
                    n_hit++;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (v < 0 && !dir_valid[i])
                            v = i;
                    end
                    // full directory: oldest stamp goes, lowest index on a tie
                    if (v < 0)
                    begin
                        v = 0;
                        for (int i = 1; i < SLOTS; i++)
                        begin
                            if (dir_stamp[i] < dir_stamp[v])
                                v = i;
                        end
                        o.evicted    = 1'b1;
                        o.evicted_id = dir_tag[v];
                        n_evict++;
                    end
                    dir_valid[v]    = 1'b1;
                    dir_tag[v]      = r.patch_id;
                    dir_stamp[v]    = dir_now;
                    dir_stale[v]    = 1'b0;
                    o.granted       = 1'b1;
                    o.slot_index    = v[6:0];
                    o.refill_needed = 1'b1;
                    n_miss++;
                end
            end
            MODE_STALE:
            begin
                if (s >= 0)
                    dir_stale[s] = 1'b1;
                n_mark++;
            end
            MODE_TICK:
            begin
                dir_now = dir_now + 32'd1;
                n_tick++;
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    dir_valid[i] = 1'b0;
                    dir_stale[i] = 1'b0;
                end
                dir_now = dir_now + 32'd1;
                n_flush++;
            end
        endcase
        return o;
    endfunction

    // one directed row; the answer is typed in when chk is set
    task automatic add_row(input mode_t m, input bit [15:0] id, input bit pres,
                           input bit dirty, input bit chk, input bit g, input bit h,
                           input bit [6:0] idx, input bit rf, input bit ev,
                           input bit [15:0] ev_id);
        req_t r;
        rsp_t w;
        r.mode           = m;
        r.patch_id       = id;
        r.source_present = pres;
        r.overlay_dirty  = dirty;
        w.granted        = g;
        w.hit            = h;
        w.slot_index     = idx;
        w.refill_needed  = rf;
        w.evicted        = ev;
        w.evicted_id     = ev_id;
        stim_q.push_back(r);
        typed_q.push_back(chk);
        typed_rsp_q.push_back(w);
    endtask

    // random traffic: mostly lookups over fresh and recently used ids
    task automatic build_random();
        req_t r;
        int   pick;
        for (int n = 0; n < RANDOM_N; n++)
        begin
            pick               = $urandom_range(0, 99);
            r.patch_id         = 16'($urandom_range(0, 65535));
            r.source_present   = 1'($urandom_range(0, 1));
            r.overlay_dirty    = 1'($urandom_range(0, 1));
            if (pick < 70)
            begin
                r.mode = MODE_LOOKUP;
                if ($urandom_range(0, 99) >= 55 && recent_ids.size() > 0)
                    r.patch_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
                r.source_present = ($urandom_range(0, 9) != 0);
                r.overlay_dirty  = ($urandom_range(0, 2) == 0);
                recent_ids.push_back(r.patch_id);
                if (recent_ids.size() > 40)
                    void'(recent_ids.pop_front());
            end
            else if (pick < 80)
            begin
                r.mode = MODE_STALE;
                if ($urandom_range(0, 4) != 0 && recent_ids.size() > 0)
                    r.patch_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            end
            // flushes only late, so the directory fills and evicts first
            else if (n > 430 && $urandom_range(0, 39) == 0)
                r.mode = MODE_FLUSH;
            else
                r.mode = MODE_TICK;
            stim_q.push_back(r);
            typed_q.push_back(1'b0);
            typed_rsp_q.push_back('0);
        end
    endtask

    // request side: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(req_valid && beats_taken == cur_idx))
            begin
                if (req_valid)
                    cur_idx = cur_idx + 1;
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (cur_idx < stim_q.size())
                begin
                    req_valid <= 1'b1;
                    req       <= stim_q[cur_idx];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result side: stall pattern of its own, clear stretches and long holds
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 7);
            stall_left = (stall_mode == 7) ? $urandom_range(40, 90) : 32;
            stall_bits = (stall_mode < 2) ? 32'd0 : $urandom;
        end
        stall_left = stall_left - 1;
        rsp_stall <= (stall_mode == 7) ? 1'b1 : stall_bits[stall_left[4:0]];
    end

    // accepted beats: predict on the request side, check on the result side
    always @(posedge clk)
    begin : beat_monitor
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                want = directory_step(req);
                if (typed_q[beats_taken])
                    pending_rsp_q.push_back(typed_rsp_q[beats_taken]);
                else
                    pending_rsp_q.push_back(want);
                beats_taken = beats_taken + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat %h at cycle %0d", rsp, cycles);
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (rsp.granted != want.granted || rsp.hit != want.hit ||
                        rsp.slot_index != want.slot_index ||
                        rsp.refill_needed != want.refill_needed ||
                        rsp.evicted != want.evicted || rsp.evicted_id != want.evicted_id)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("result %0d: want g%0b h%0b s%0d r%0b e%0b id %h, got g%0b h%0b s%0d r%0b e%0b id %h",
                                     n_results, want.granted, want.hit, want.slot_index,
                                     want.refill_needed, want.evicted, want.evicted_id,
                                     rsp.granted, rsp.hit, rsp.slot_index,
                                     rsp.refill_needed, rsp.evicted, rsp.evicted_id);
                    end
                    n_results++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats sent, %0d results",
                     cycles, beats_taken, n_results);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        // directed rows, answers read straight off the directory behaviour
        add_row(MODE_LOOKUP, 16'h0000, 1, 0, 1, 1, 0, 0, 1, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hFFFF, 1, 1, 1, 1, 0, 1, 1, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h0000, 1, 0, 1, 1, 1, 0, 0, 0, 16'h0000);
        add_row(MODE_STALE,  16'hFFFF, 0, 1, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hFFFF, 1, 0, 1, 1, 1, 1, 1, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hFFFF, 1, 0, 1, 1, 1, 1, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h0000, 1, 1, 1, 1, 1, 0, 1, 0, 16'h0000);
        add_row(MODE_TICK,   16'hFFFF, 1, 1, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h0000, 0, 1, 1, 0, 0, 0, 0, 1, 16'h0000);
        add_row(MODE_LOOKUP, 16'hFFFF, 0, 0, 1, 0, 0, 0, 0, 1, 16'hFFFF);
        add_row(MODE_LOOKUP, 16'h1234, 0, 0, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_STALE,  16'h5555, 1, 0, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h5555, 1, 0, 1, 1, 0, 0, 1, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hAAAA, 1, 0, 1, 1, 0, 1, 1, 0, 16'h0000);
        add_row(MODE_STALE,  16'h5555, 0, 0, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_FLUSH,  16'hAAAA, 1, 1, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hAAAA, 1, 0, 1, 1, 0, 0, 1, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h5555, 1, 0, 1, 1, 0, 1, 1, 0, 16'h0000);
        add_row(MODE_STALE,  16'h5555, 1, 1, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'h5555, 0, 0, 1, 0, 0, 0, 0, 1, 16'h5555);
        add_row(MODE_LOOKUP, 16'h5555, 1, 0, 1, 1, 0, 1, 1, 0, 16'h0000);
        add_row(MODE_TICK,   16'h0000, 0, 0, 1, 0, 0, 0, 0, 0, 16'h0000);
        add_row(MODE_LOOKUP, 16'hAAAA, 1, 0, 1, 1, 1, 0, 0, 0, 16'h0000);
        add_row(MODE_FLUSH,  16'h0000, 0, 0, 1, 0, 0, 0, 0, 0, 16'h0000);
        build_random();

        dir_now = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (beats_taken < stim_q.size() || pending_rsp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("%0d beats, %0d results: %0d hits, %0d misses, %0d evictions, %0d frees",
                 beats_taken, n_results, n_hit, n_miss, n_evict, n_free);
        $display("%0d stale marks, %0d ticks, %0d flushes, %0d mismatches",
                 n_mark, n_tick, n_flush, fails);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
